// ===== design/etcr_pkg.sv =====
// Shared types and constants for the encoder tick counter and tachometer.
`default_nettype none
package etcr_pkg;

  typedef enum logic [2:0] {
    ACT_MS_TICK     = 3'd0,
    ACT_LEFT_PULSE  = 3'd1,
    ACT_RIGHT_PULSE = 3'd2,
    ACT_SET_DIR     = 3'd3,
    ACT_READ        = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DMUL,
    ST_DSAVE,
    ST_NMUL,
    ST_BIG,
    ST_DIV,
    ST_WSAVE,
    ST_DONE
  } state_t;

  localparam int COUNT_WIDTH_DEF     = 32;
  localparam int TIME_WIDTH_DEF      = 32;
  localparam int SPEED_FRAC_BITS_DEF = 4;

  localparam int DIR_W = 8;
  localparam int PPR_W = 10;
  localparam logic [PPR_W-1:0] PPR_RESET = 10'd20;

  localparam int OUT_W  = 32;
  localparam int QUO_W  = OUT_W + 1;
  localparam int STEP_W = $clog2(QUO_W);

  // 60 s/min * 1000 ms/s
  localparam int RPM_SCALE   = 60000;
  localparam int RPM_SCALE_W = 16;

  localparam logic [OUT_W-1:0] SPEED_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SPEED_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage
`default_nettype wire

// ===== design/encoder_tick_counter_rpm_unit.sv =====
// Two-wheel encoder tick counter with a shared shift-add / restoring-divide speed unit.
// Tick, pulse and set-direction items are applied in idle; in_ready is high whenever idle.
// A read runs, on one shared adder/subtractor, a 10-step multiply for the divisor,
// then per wheel a KW-step multiply (KW = 16 + SPEED_FRAC_BITS) and a 33-step
// restoring divide.
// Reset (rst, synchronous) clears counts, signs, times and sets pulses_per_rev to 20.
`default_nettype none
module encoder_tick_counter_rpm_unit #(
  parameter int COUNT_WIDTH     = etcr_pkg::COUNT_WIDTH_DEF,
  parameter int TIME_WIDTH      = etcr_pkg::TIME_WIDTH_DEF,
  parameter int SPEED_FRAC_BITS = etcr_pkg::SPEED_FRAC_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [2:0]                       action,
  input  wire  signed [etcr_pkg::DIR_W-1:0] left_dir_cmd,
  input  wire  signed [etcr_pkg::DIR_W-1:0] right_dir_cmd,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [etcr_pkg::OUT_W-1:0] left_total,
  output logic signed [etcr_pkg::OUT_W-1:0] right_total,
  output logic signed [etcr_pkg::OUT_W-1:0] left_speed,
  output logic signed [etcr_pkg::OUT_W-1:0] right_speed,
  input  wire                              cfg_wr_en,
  input  wire  [etcr_pkg::PPR_W-1:0]       cfg_wr_data
);

  localparam int OUT_W  = etcr_pkg::OUT_W;
  localparam int QUO_W  = etcr_pkg::QUO_W;
  localparam int STEP_W = etcr_pkg::STEP_W;
  localparam int PPR_W  = etcr_pkg::PPR_W;
  localparam int KW     = etcr_pkg::RPM_SCALE_W + SPEED_FRAC_BITS;
  localparam logic [KW-1:0] KVAL = KW'(etcr_pkg::RPM_SCALE) << SPEED_FRAC_BITS;
  localparam int DW     = TIME_WIDTH + PPR_W;
  localparam int NW     = COUNT_WIDTH + KW;
  localparam int XW     = (NW > DW + QUO_W) ? NW : DW + QUO_W;

  etcr_pkg::state_t state, state_next;

  logic [PPR_W-1:0]       ppr;
  logic [COUNT_WIDTH-1:0] left_count, right_count, left_prev, right_prev;
  logic [1:0]             left_sign, right_sign;
  logic [TIME_WIDTH-1:0]  now_ms, prev_ms;
  logic [TIME_WIDTH-1:0]  elapsed;

  // read snapshot
  logic [COUNT_WIDTH-1:0] delta_l, delta_r;
  logic [OUT_W-1:0]       ltot, rtot, lspd, rspd;

  // shared unit and sequencer
  logic [XW-1:0]     acc, opr;
  logic [DW-1:0]     dval;
  logic [KW-1:0]     mplr;
  logic [STEP_W-1:0] cnt;
  logic [QUO_W-1:0]  quo;
  logic              big;
  logic              wheel;
  logic              op_sub;
  logic [XW:0]       sum;
  logic              ge;

  logic [COUNT_WIDTH-1:0] mag_l, mag_r;
  logic                   cur_neg;
  logic [OUT_W-1:0]       spd_sat;
  logic                   accept;

  assign accept  = in_valid && in_ready;
  // wraps within TIME_WIDTH
  assign elapsed = now_ms - prev_ms;
  assign mag_l   = delta_l[COUNT_WIDTH-1] ? -delta_l : delta_l;
  assign mag_r   = delta_r[COUNT_WIDTH-1] ? -delta_r : delta_r;
  assign sum     = op_sub ? ({1'b0, acc} - {1'b0, opr}) : ({1'b0, acc} + {1'b0, opr});
  assign ge      = ~sum[XW];

  always_comb begin
    cur_neg = wheel ? delta_r[COUNT_WIDTH-1] : delta_l[COUNT_WIDTH-1];
    if (dval == '0) begin
      spd_sat = '0;
    end else if (!cur_neg) begin
      spd_sat = (big || quo[QUO_W-1] || quo[OUT_W-1]) ? etcr_pkg::SPEED_MAX
                                                      : quo[OUT_W-1:0];
    end else begin
      // magnitude of exactly 2^31 still fits on the negative side
      spd_sat = (big || quo > (QUO_W'(1) << (OUT_W-1))) ? etcr_pkg::SPEED_MIN
                                                        : -quo[OUT_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      etcr_pkg::ST_IDLE:
        if (accept && action == etcr_pkg::ACT_READ) state_next = etcr_pkg::ST_DMUL;
      etcr_pkg::ST_DMUL:
        if (cnt == STEP_W'(PPR_W-1)) state_next = etcr_pkg::ST_DSAVE;
      etcr_pkg::ST_DSAVE: state_next = etcr_pkg::ST_NMUL;
      etcr_pkg::ST_NMUL:
        if (cnt == STEP_W'(KW-1)) state_next = etcr_pkg::ST_BIG;
      etcr_pkg::ST_BIG:   state_next = etcr_pkg::ST_DIV;
      etcr_pkg::ST_DIV:
        if (cnt == STEP_W'(QUO_W-1)) state_next = etcr_pkg::ST_WSAVE;
      etcr_pkg::ST_WSAVE:
        state_next = wheel ? etcr_pkg::ST_DONE : etcr_pkg::ST_NMUL;
      etcr_pkg::ST_DONE:
        if (!out_valid || out_ready) state_next = etcr_pkg::ST_IDLE;
      default: state_next = etcr_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    op_sub   = 1'b0;
    unique case (state)
      etcr_pkg::ST_IDLE: in_ready = 1'b1;
      etcr_pkg::ST_BIG,
      etcr_pkg::ST_DIV:  op_sub = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= etcr_pkg::ST_IDLE;
      out_valid   <= 1'b0;
      ppr         <= etcr_pkg::PPR_RESET;
      left_count  <= '0;
      right_count <= '0;
      left_prev   <= '0;
      right_prev  <= '0;
      left_sign   <= '0;
      right_sign  <= '0;
      now_ms      <= '0;
      prev_ms     <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) ppr <= cfg_wr_data;
      if (state == etcr_pkg::ST_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready)                            out_valid <= 1'b0;

      unique case (state)
        etcr_pkg::ST_IDLE: begin
          if (accept) begin
            case (action)
              etcr_pkg::ACT_MS_TICK: now_ms <= now_ms + TIME_WIDTH'(1);
              etcr_pkg::ACT_LEFT_PULSE:
                left_count <= left_count + COUNT_WIDTH'($signed(left_sign));
              etcr_pkg::ACT_RIGHT_PULSE:
                right_count <= right_count + COUNT_WIDTH'($signed(right_sign));
              etcr_pkg::ACT_SET_DIR: begin
                // -1 -> 2'b11, 0 -> 2'b00, +1 -> 2'b01
                left_sign  <= {left_dir_cmd[etcr_pkg::DIR_W-1], left_dir_cmd != '0};
                right_sign <= {right_dir_cmd[etcr_pkg::DIR_W-1], right_dir_cmd != '0};
              end
              etcr_pkg::ACT_READ: begin
                delta_l    <= left_count - left_prev;
                delta_r    <= right_count - right_prev;
                ltot       <= OUT_W'($signed(left_count));
                rtot       <= OUT_W'($signed(right_count));
                left_prev  <= left_count;
                right_prev <= right_count;
                prev_ms    <= now_ms;
                acc        <= '0;
                opr        <= XW'(elapsed);
                mplr       <= KW'(ppr);
                cnt        <= '0;
                wheel      <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        etcr_pkg::ST_DMUL: begin
          // divisor = elapsed * ppr, LSB-first shift-add
          if (mplr[0]) acc <= sum[XW-1:0];
          opr  <= opr << 1;
          mplr <= mplr >> 1;
          cnt  <= cnt + STEP_W'(1);
        end
        etcr_pkg::ST_DSAVE: begin
          dval <= acc[DW-1:0];
          acc  <= '0;
          opr  <= XW'(mag_l);
          mplr <= KVAL;
          cnt  <= '0;
        end
        etcr_pkg::ST_NMUL: begin
          // numerator = |delta| * scale
          if (mplr[0]) acc <= sum[XW-1:0];
          mplr <= mplr >> 1;
          cnt  <= cnt + STEP_W'(1);
          if (cnt == STEP_W'(KW-1)) opr <= XW'(dval) << QUO_W;
          else                      opr <= opr << 1;
        end
        etcr_pkg::ST_BIG: begin
          // quotient needs more than QUO_W bits: saturates unless the divisor is zero
          big <= ge;
          opr <= opr >> 1;
          cnt <= '0;
          quo <= '0;
        end
        etcr_pkg::ST_DIV: begin
          if (ge) acc <= sum[XW-1:0];
          quo <= {quo[QUO_W-2:0], ge};
          opr <= opr >> 1;
          cnt <= cnt + STEP_W'(1);
        end
        etcr_pkg::ST_WSAVE: begin
          if (!wheel) begin
            lspd  <= spd_sat;
            wheel <= 1'b1;
            acc   <= '0;
            opr   <= XW'(mag_r);
            mplr  <= KVAL;
            cnt   <= '0;
          end else begin
            rspd <= spd_sat;
          end
        end
        etcr_pkg::ST_DONE: begin
          if (!out_valid || out_ready) begin
            left_total  <= ltot;
            right_total <= rtot;
            left_speed  <= lspd;
            right_speed <= rspd;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_only_on_pulse: assert property (@(posedge clk) disable iff (rst)
    !$stable(left_count) |->
      $past(in_valid && in_ready && action == etcr_pkg::ACT_LEFT_PULSE))
    else $error("left count changed without a left pulse item");

  a_read_starts_unit: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == etcr_pkg::ACT_READ) |=>
      (state == etcr_pkg::ST_DMUL))
    else $error("accepted read did not start the speed unit");

  a_speed_sign: assert property (@(posedge clk) disable iff (rst)
    (state == etcr_pkg::ST_WSAVE && !wheel && !delta_l[COUNT_WIDTH-1]) |=>
      !lspd[OUT_W-1])
    else $error("negative left speed for non-negative tick delta");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_encoder_tick_counter_rpm_unit.sv =====
// Self-checking testbench for the two-wheel encoder tick counter and rpm unit.
module tb_encoder_tick_counter_rpm_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import etcr_pkg::*;

  // codes the block ignores
  localparam logic [2:0] ACT_RSVD [3] = '{3'd5, 3'd6, 3'd7};
  localparam logic [PPR_W-1:0] PPR_MAX = '1;
  localparam logic [PPR_W-1:0] PPR_NONE = '0;
  localparam int READ_LAT     = 140;
  localparam int CYC_LIMIT    = 2_000_000;
  localparam int BURST_PULSES = 40;
  localparam int LONG_HOLD    = 500;

  typedef struct {
    logic [2:0]       act;
    logic [DIR_W-1:0] ldir;
    logic [DIR_W-1:0] rdir;
    bit               wait_drain;
  } enc_op_t;

  typedef struct {
    logic [OUT_W-1:0] ltot;
    logic [OUT_W-1:0] rtot;
    logic [OUT_W-1:0] lspd;
    logic [OUT_W-1:0] rspd;
  } readout_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [PPR_W-1:0] cfg_wr_data = PPR_RESET;
  logic [2:0] action = ACT_MS_TICK;
  logic signed [DIR_W-1:0] left_dir_cmd = '0;
  logic signed [DIR_W-1:0] right_dir_cmd = '0;
  logic in_ready, out_valid;
  logic signed [OUT_W-1:0] left_total, right_total, left_speed, right_speed;

  enc_op_t  op_backlog [$];
  readout_t readouts_due [$];

  // predictor state
  logic [PPR_W-1:0] m_ppr = PPR_RESET;
  logic [COUNT_WIDTH_DEF-1:0] m_lcnt = '0, m_rcnt = '0, m_lref = '0, m_rref = '0;
  logic [TIME_WIDTH_DEF-1:0] m_now = '0, m_then = '0;
  int m_lsgn = 0, m_rsgn = 0;

  int n_acc = 0, n_seen = 0, n_items = 0, n_reads = 0, n_still = 0, n_sat = 0, n_err = 0;
  int tx_gap = 0, tx_calm = 0, rx_hold = 0, rx_calm = 0;
  int hold_req = 0, hold_ack = 0;

  encoder_tick_counter_rpm_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .left_dir_cmd (left_dir_cmd),
    .right_dir_cmd(right_dir_cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .left_total   (left_total),
    .right_total  (right_total),
    .left_speed   (left_speed),
    .right_speed  (right_speed),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // 1/16 rpm from tick delta, elapsed ms and pulses per rev; exact, truncated, saturated
  function automatic logic [OUT_W-1:0] wheel_rpm16(logic [31:0] cnt, logic [31:0] base,
                                                  logic [31:0] dt, logic [PPR_W-1:0] ppr);
    logic [31:0] d;
    logic [63:0] num, den, q;
    d = cnt - base;
    num = {32'd0, d[31] ? (~d + 32'd1) : d} * (64'(RPM_SCALE) << SPEED_FRAC_BITS_DEF);
    den = 64'(dt) * 64'(ppr);
    if (den == 0) return '0;
    q = num / den;
    if (!d[31]) return (q > 64'(SPEED_MAX)) ? SPEED_MAX : q[31:0];
    return (q > 64'(SPEED_MIN)) ? SPEED_MIN : (~q[31:0] + 32'd1);
  endfunction

  function automatic int dir_sign(logic [DIR_W-1:0] c);
    if (c == 0) return 0;
    return c[DIR_W-1] ? -1 : 1;
  endfunction

  function automatic logic [DIR_W-1:0] pick_dir();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'hFF;
      default: return DIR_W'($urandom);
    endcase
  endfunction

  task automatic track_wheels(logic [2:0] a, logic [DIR_W-1:0] l, logic [DIR_W-1:0] r);
    readout_t ro;
    if (a <= ACT_READ) n_items++;
    case (a)
      ACT_MS_TICK:     m_now = m_now + 1'b1;
      ACT_LEFT_PULSE:  m_lcnt = m_lcnt + 32'(m_lsgn);
      ACT_RIGHT_PULSE: m_rcnt = m_rcnt + 32'(m_rsgn);
      ACT_SET_DIR: begin
        m_lsgn = dir_sign(l);
        m_rsgn = dir_sign(r);
      end
      ACT_READ: begin
        ro.ltot = m_lcnt;
        ro.rtot = m_rcnt;
        ro.lspd = wheel_rpm16(m_lcnt, m_lref, m_now - m_then, m_ppr);
        ro.rspd = wheel_rpm16(m_rcnt, m_rref, m_now - m_then, m_ppr);
        readouts_due.push_back(ro);
        n_reads++;
        if (m_now == m_then) n_still++;
        if (ro.lspd == SPEED_MAX || ro.lspd == SPEED_MIN) n_sat++;
        if (ro.rspd == SPEED_MAX || ro.rspd == SPEED_MIN) n_sat++;
        m_lref = m_lcnt;
        m_rref = m_rcnt;
        m_then = m_now;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string nm, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
    if (want !== got) begin
      n_err++;
      $display("%0t: %s mismatch: expected %0d (%h), actual %0d (%h)",
               $time, nm, $signed(want), want, $signed(got), got);
    end
  endtask

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    readout_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        n_acc++;
        track_wheels(action, left_dir_cmd, right_dir_cmd);
      end
      if (out_valid && out_ready) begin
        if (readouts_due.size() == 0) begin
          n_err++;
          $display("%0t: unexpected result: expected none, actual %h %h %h %h", $time,
                   left_total, right_total, left_speed, right_speed);
        end else begin
          want = readouts_due.pop_front();
          check_field("left_total", want.ltot, left_total);
          check_field("right_total", want.rtot, right_total);
          check_field("left_speed", want.lspd, left_speed);
          check_field("right_speed", want.rspd, right_speed);
        end
      end
    end
  end

  // item driver
  always @(negedge clk) begin
    logic nv;
    int pick;
    enc_op_t op;
    nv = in_valid;
    if (in_valid && n_acc != n_seen) begin
      n_seen = n_acc;
      nv = 1'b0;
    end
    if (!rst && !nv) begin
      if (tx_gap > 0) tx_gap--;
      else if (op_backlog.size() > 0 &&
               !(op_backlog[0].wait_drain && readouts_due.size() > 0)) begin
        op = op_backlog.pop_front();
        action <= op.act;
        left_dir_cmd <= op.ldir;
        right_dir_cmd <= op.rdir;
        nv = 1'b1;
        if (tx_calm > 0) begin
          tx_calm--;
          tx_gap = 0;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 3) tx_calm = $urandom_range(30, 150);
          tx_gap = (pick < 10) ? $urandom_range(15, 60) :
                   (pick < 45) ? $urandom_range(1, 3) : 0;
        end
      end
    end
    in_valid <= nv;
  end

  // result receiver backpressure
  always @(negedge clk) begin
    logic rdy;
    int pick;
    rdy = 1'b1;
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      rx_hold = LONG_HOLD;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      rdy = 1'b0;
    end else if (rx_calm > 0) begin
      rx_calm--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 2) rx_calm = $urandom_range(40, 200);
      else if (pick < 6) begin
        rx_hold = $urandom_range(15, 80);
        rdy = 1'b0;
      end else if (pick < 30) begin
        rx_hold = $urandom_range(0, 3);
        rdy = 1'b0;
      end
    end
    out_ready <= rdy;
  end

  initial begin
    int cyc;
    cyc = 0;
    while (cyc < CYC_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("timeout after %0d cycles", CYC_LIMIT);
    $display("tb_encoder_tick_counter_rpm_unit: done, errors");
    $finish;
  end

  task automatic queue_op(logic [2:0] a, logic [DIR_W-1:0] l = '0,
                          logic [DIR_W-1:0] r = '0, bit w = 1'b0);
    enc_op_t op;
    op.act = a;
    op.ldir = l;
    op.rdir = r;
    op.wait_drain = w;
    op_backlog.push_back(op);
  endtask

  // mostly direction / pulses / ticks / read sequences, some noise
  task automatic random_run(int n);
    int cnt, k, t, i;
    logic [2:0] a;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 99) < 12) begin
        k = $urandom_range(1, 3);
        for (i = 0; i < k; i++) begin
          a = 3'($urandom_range(0, 7));
          queue_op(a, pick_dir(), pick_dir());
          if (a <= ACT_READ) cnt++;
        end
      end else begin
        if ($urandom_range(0, 9) < 7) begin
          queue_op(ACT_SET_DIR, pick_dir(), pick_dir());
          cnt++;
        end
        k = $urandom_range(0, 12);
        t = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        while (k + t > 0) begin
          if ($urandom_range(1, k + t) <= k) begin
            queue_op($urandom_range(0, 1) ? ACT_LEFT_PULSE : ACT_RIGHT_PULSE);
            k--;
          end else begin
            queue_op(ACT_MS_TICK);
            t--;
          end
          cnt++;
        end
        queue_op(ACT_READ, pick_dir(), pick_dir(), $urandom_range(0, 9) == 0);
        cnt++;
      end
    end
  endtask

  // block idle: nothing queued, nothing in flight, then the read latency
  task automatic settle();
    while (op_backlog.size() > 0 || in_valid || readouts_due.size() > 0) @(posedge clk);
    repeat (READ_LAT) @(posedge clk);
  endtask

  task automatic write_ppr(logic [PPR_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    m_ppr = v;
  endtask

  initial begin
    int i;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, default pulses per rev
    queue_op(ACT_READ);                    // all zero, no time elapsed
    queue_op(ACT_SET_DIR, 8'h7F, 8'h80);
    queue_op(ACT_LEFT_PULSE);
    queue_op(ACT_RIGHT_PULSE);
    queue_op(ACT_LEFT_PULSE);
    queue_op(ACT_RIGHT_PULSE);
    queue_op(ACT_MS_TICK);
    queue_op(ACT_READ);
    queue_op(ACT_READ);                    // same ms again: zero speed
    queue_op(ACT_SET_DIR, 8'h00, 8'h00);   // stopped wheels ignore pulses
    queue_op(ACT_LEFT_PULSE);
    queue_op(ACT_RIGHT_PULSE);
    for (i = 0; i < 3; i++) queue_op(ACT_RSVD[i], 8'hFF, 8'hFF);
    queue_op(ACT_SET_DIR, 8'hFF, 8'h01);
    queue_op(ACT_LEFT_PULSE);
    queue_op(ACT_LEFT_PULSE);
    queue_op(ACT_LEFT_PULSE);
    queue_op(ACT_RIGHT_PULSE);
    queue_op(ACT_MS_TICK);
    queue_op(ACT_MS_TICK);
    queue_op(ACT_READ, 8'hFF, 8'hFF);
    settle();

    // fast wheels in both directions: a burst of ticks in one ms at one pulse per rev
    write_ppr(10'd1);
    queue_op(ACT_SET_DIR, 8'h01, 8'hFF);
    for (i = 0; i < BURST_PULSES; i++) begin
      queue_op(ACT_LEFT_PULSE);
      queue_op(ACT_RIGHT_PULSE);
    end
    queue_op(ACT_MS_TICK);
    queue_op(ACT_READ);
    settle();

    write_ppr(PPR_MAX);
    random_run(150);
    settle();
    write_ppr(PPR_NONE);
    random_run(80);
    settle();
    write_ppr(10'd1);
    random_run(120);
    repeat (2) begin
      settle();
      write_ppr(PPR_W'($urandom_range(2, 1022)));
      random_run(150);
    end
    settle();
    write_ppr(PPR_W'($urandom_range(2, 1022)));
    hold_req++;                            // long receiver stall keeps the block busy
    random_run(150);
    settle();

    $display("run: %0d items, %0d reads, %0d at zero elapsed time, %0d saturated speeds",
             n_items, n_reads, n_still, n_sat);
    $display("pulses per rev swept over reset, 0, 1, 1023 and random; %0d mismatches", n_err);
    if (n_err == 0) $display("tb_encoder_tick_counter_rpm_unit: done, clean");
    else $display("tb_encoder_tick_counter_rpm_unit: done, errors");
    $finish;
  end

endmodule
